// File: rtl/mandelbrot_escape_time_core_macros.svh
// assertion macros for the mandelbrot escape-time core
`ifndef MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MET_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MET_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/met_pkg.sv
// shared types, constants and the multiply schedule of the escape-time core
package met_pkg;

    localparam int STEP_W     = 16;
    localparam int RADIUS_W   = 11;
    localparam int R2_W       = 2 * RADIUS_W;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int C_W        = 32;
    localparam int Z_W        = 64;
    localparam int C_SHIFT    = 11;
    localparam int MAG_W      = 51;
    localparam int HALF_W     = 32;
    localparam int HI_W       = MAG_W - HALF_W;
    localparam int PROD_W     = 2 * HALF_W;
    localparam int ACC_W      = 104;
    localparam int FRAC_W     = 40;
    localparam int LIMIT_SHIFT = 80;
    localparam int OP_IDX_W   = 3;
    localparam int SQ_OPS     = 6;
    localparam int PR_OPS     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 1'b1;

    localparam logic [STEP_W-1:0] MAX_ITER_RESET = 16'd100;
    localparam logic [R2_W-1:0]   R2_RESET       = R2_W'(1000 * 1000);

    // round-half-up offsets for the real (2^-40) and imaginary (2^-39) rescale
    localparam logic [ACC_W-1:0] RND_RE = ACC_W'(1) << (FRAC_W - 1);
    localparam logic [ACC_W-1:0] RND_IM = ACC_W'(1) << (FRAC_W - 2);

    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_33,
        SH_64
    } shift_t;

    typedef enum logic [1:0] {
        ACC_RE2,
        ACC_IM2,
        ACC_PRD
    } acc_t;

    typedef struct packed {
        logic   a_im;
        logic   a_hi;
        logic   b_im;
        logic   b_hi;
        shift_t shift;
        acc_t   target;
    } mul_op_t;

    typedef struct packed {
        logic   valid;
        shift_t shift;
        acc_t   target;
    } mul_tag_t;

    function automatic mul_op_t met_mk(input logic a_im, input logic a_hi, input logic b_im,
                                       input logic b_hi, input shift_t shift,
                                       input acc_t target);
        mul_op_t op;
        op.a_im   = a_im;
        op.a_hi   = a_hi;
        op.b_im   = b_im;
        op.b_hi   = b_hi;
        op.shift  = shift;
        op.target = target;
        return op;
    endfunction

    // partial products: squares use lo*lo, 2*lo*hi, hi*hi; the cross product all four
    function automatic mul_op_t met_op(input logic sq_phase, input logic [OP_IDX_W-1:0] idx);
        mul_op_t op;
        op = met_mk(1'b0, 1'b0, 1'b0, 1'b0, SH_0, ACC_RE2);
        if (sq_phase)
        begin
            unique case (idx)
                3'd0:    op = met_mk(1'b0, 1'b0, 1'b0, 1'b0, SH_0,  ACC_RE2);
                3'd1:    op = met_mk(1'b0, 1'b0, 1'b0, 1'b1, SH_33, ACC_RE2);
                3'd2:    op = met_mk(1'b0, 1'b1, 1'b0, 1'b1, SH_64, ACC_RE2);
                3'd3:    op = met_mk(1'b1, 1'b0, 1'b1, 1'b0, SH_0,  ACC_IM2);
                3'd4:    op = met_mk(1'b1, 1'b0, 1'b1, 1'b1, SH_33, ACC_IM2);
                3'd5:    op = met_mk(1'b1, 1'b1, 1'b1, 1'b1, SH_64, ACC_IM2);
                default: op = met_mk(1'b0, 1'b0, 1'b0, 1'b0, SH_0,  ACC_RE2);
            endcase
        end
        else
        begin
            unique case (idx)
                3'd0:    op = met_mk(1'b0, 1'b0, 1'b1, 1'b0, SH_0,  ACC_PRD);
                3'd1:    op = met_mk(1'b0, 1'b0, 1'b1, 1'b1, SH_32, ACC_PRD);
                3'd2:    op = met_mk(1'b0, 1'b1, 1'b1, 1'b0, SH_32, ACC_PRD);
                3'd3:    op = met_mk(1'b0, 1'b1, 1'b1, 1'b1, SH_64, ACC_PRD);
                default: op = met_mk(1'b0, 1'b0, 1'b1, 1'b0, SH_0,  ACC_PRD);
            endcase
        end
        return op;
    endfunction

endpackage

// File: rtl/met_cfg.sv
// configuration registers: iteration limit and squared escape radius
module met_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [met_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [met_pkg::CFG_W-1:0]        cfg_wdata,
    output logic [met_pkg::STEP_W-1:0]       max_iter,
    output logic [met_pkg::R2_W-1:0]         radius_sq
);
    import met_pkg::*;

    logic [STEP_W-1:0]   max_iter_reg;
    logic [R2_W-1:0]     radius_sq_reg;
    logic [RADIUS_W-1:0] radius_in;

    assign radius_in = cfg_wdata[RADIUS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg  <= MAX_ITER_RESET;
            radius_sq_reg <= R2_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_ITER: max_iter_reg  <= cfg_wdata[STEP_W-1:0];
                CFG_RADIUS:   radius_sq_reg <= R2_W'(radius_in) * R2_W'(radius_in);
                default:      ;
            endcase
        end
    end

    assign max_iter  = max_iter_reg;
    assign radius_sq = radius_sq_reg;

endmodule

// File: rtl/met_mul.sv
// shared 32x32 unsigned multiplier with registered product and routing tag
module met_mul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          issue,
    input  logic [met_pkg::HALF_W-1:0]    op_a,
    input  logic [met_pkg::HALF_W-1:0]    op_b,
    input  met_pkg::shift_t               shift,
    input  met_pkg::acc_t                 target,
    output logic [met_pkg::PROD_W-1:0]    prod,
    output met_pkg::mul_tag_t             prod_tag
);
    import met_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    mul_tag_t          tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg.valid  <= issue;
            tag_reg.shift  <= shift;
            tag_reg.target <= target;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign prod     = prod_reg;
    assign prod_tag = tag_reg;

endmodule

// File: rtl/mandelbrot_escape_time_core.sv
// escape-time iteration core: takes point c, returns first escaping step or 0
// run time grows with the steps run; z leaving the safe range ends an item early
// a new point is accepted only after the previous result is loaded into the output register
// input ready only while idle, result held in output register
// a full step runs two squares and one cross product as partial products on the shared 32x32 multiplier
// reset: async active low; limit returns to 100, radius to 1000, block idle with no result
`include "mandelbrot_escape_time_core_macros.svh"

module mandelbrot_escape_time_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [63:0]                        s_tdata,   // c_re[31:0], c_im[63:32]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // escape_step[15:0]
    input  logic                               cfg_we,
    input  logic [met_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [met_pkg::CFG_W-1:0]          cfg_wdata
);
    import met_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG,
        ST_SQ,
        ST_SQ_WAIT,
        ST_TEST,
        ST_PR,
        ST_PR_WAIT,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic                first_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   lim_reg;
    logic [OP_IDX_W-1:0] op_idx_reg;
    logic [STEP_W-1:0]   res_reg;
    logic                m_tvalid_reg;
    logic [STEP_W-1:0]   m_tdata_reg;

    logic [Z_W-1:0]      z_re_reg;
    logic [Z_W-1:0]      z_im_reg;
    logic [Z_W-1:0]      c_re_reg;
    logic [Z_W-1:0]      c_im_reg;
    logic [MAG_W-1:0]    mag_re_reg;
    logic [MAG_W-1:0]    mag_im_reg;
    logic                neg_prd_reg;
    logic [ACC_W-1:0]    sq_re_reg;
    logic [ACC_W-1:0]    sq_im_reg;
    logic [ACC_W-1:0]    prd_reg;

    logic [STEP_W-1:0]   max_iter;
    logic [R2_W-1:0]     radius_sq;

    logic [Z_W-1:0]      mag_re_full;
    logic [Z_W-1:0]      mag_im_full;
    logic                z_big;
    mul_op_t             op;
    logic                issue;
    logic [MAG_W-1:0]    src_a;
    logic [MAG_W-1:0]    src_b;
    logic [HALF_W-1:0]   op_a;
    logic [HALF_W-1:0]   op_b;
    logic [PROD_W-1:0]   prod;
    mul_tag_t            prod_tag;
    logic [ACC_W-1:0]    addend;
    logic [ACC_W:0]      mag_sq;
    logic [ACC_W:0]      limit;
    logic [ACC_W-1:0]    d_full;
    logic [ACC_W-1:0]    p_full;
    logic [Z_W-1:0]      c_re_in;
    logic [Z_W-1:0]      c_im_in;
    logic                last_step;

    met_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .max_iter  (max_iter),
        .radius_sq (radius_sq)
    );

    // c in Q3.29 lifted to the Q24.40 z format
    assign c_re_in = {{(Z_W - C_W - C_SHIFT){s_tdata[C_W-1]}}, s_tdata[C_W-1:0],
                      {C_SHIFT{1'b0}}};
    assign c_im_in = {{(Z_W - C_W - C_SHIFT){s_tdata[2*C_W-1]}}, s_tdata[2*C_W-1:C_W],
                      {C_SHIFT{1'b0}}};

    assign mag_re_full = z_re_reg[Z_W-1] ? (Z_W'(0) - z_re_reg) : z_re_reg;
    assign mag_im_full = z_im_reg[Z_W-1] ? (Z_W'(0) - z_im_reg) : z_im_reg;
    // a component of magnitude 2^11 or more (bit 51 up) already puts |z|^2 past any radius
    assign z_big = (|mag_re_full[Z_W-1:MAG_W]) | (|mag_im_full[Z_W-1:MAG_W]);

    assign op    = met_op(state_reg == ST_SQ, op_idx_reg);
    assign issue = (state_reg == ST_SQ) || (state_reg == ST_PR);
    assign src_a = op.a_im ? mag_im_reg : mag_re_reg;
    assign src_b = op.b_im ? mag_im_reg : mag_re_reg;
    assign op_a  = op.a_hi ? HALF_W'(src_a[MAG_W-1:HALF_W]) : src_a[HALF_W-1:0];
    assign op_b  = op.b_hi ? HALF_W'(src_b[MAG_W-1:HALF_W]) : src_b[HALF_W-1:0];

    met_mul u_mul
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (issue),
        .op_a     (op_a),
        .op_b     (op_b),
        .shift    (op.shift),
        .target   (op.target),
        .prod     (prod),
        .prod_tag (prod_tag)
    );

    always_comb
    begin
        unique case (prod_tag.shift)
            SH_0:    addend = ACC_W'(prod);
            SH_32:   addend = ACC_W'(prod) << 32;
            SH_33:   addend = ACC_W'(prod) << 33;
            SH_64:   addend = ACC_W'(prod) << 64;
            default: addend = ACC_W'(prod);
        endcase
    end

    assign mag_sq = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    assign limit  = {(ACC_W + 1 - R2_W - LIMIT_SHIFT)'(0), radius_sq, {LIMIT_SHIFT{1'b0}}};
    assign d_full = sq_re_reg - sq_im_reg + RND_RE;
    assign p_full = (neg_prd_reg ? (ACC_W'(0) - prd_reg) : prd_reg) + RND_IM;
    assign last_step = ({1'b0, step_reg} + 17'd1) == {1'b0, lim_reg};

    // control and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            first_reg    <= 1'b0;
            step_reg     <= '0;
            lim_reg      <= '0;
            op_idx_reg   <= '0;
            res_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            // a finished item reloads the output register itself in the done state
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        step_reg  <= STEP_W'(1);
                        lim_reg   <= max_iter;
                        first_reg <= 1'b1;
                        if (max_iter <= STEP_W'(1))
                        begin
                            res_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_MAG;
                        end
                    end
                end
                ST_MAG:
                begin
                    op_idx_reg <= '0;
                    if (!first_reg && z_big)
                    begin
                        res_reg   <= step_reg;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    op_idx_reg <= op_idx_reg + OP_IDX_W'(1);
                    if (op_idx_reg == OP_IDX_W'(SQ_OPS - 1))
                    begin
                        state_reg <= ST_SQ_WAIT;
                    end
                end
                ST_SQ_WAIT:
                begin
                    state_reg <= ST_TEST;
                end
                ST_TEST:
                begin
                    op_idx_reg <= '0;
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                        state_reg <= ST_PR;
                    end
                    else if (mag_sq > limit)
                    begin
                        res_reg   <= step_reg;
                        state_reg <= ST_DONE;
                    end
                    else if (last_step)
                    begin
                        res_reg   <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        step_reg  <= step_reg + STEP_W'(1);
                        state_reg <= ST_PR;
                    end
                end
                ST_PR:
                begin
                    op_idx_reg <= op_idx_reg + OP_IDX_W'(1);
                    if (op_idx_reg == OP_IDX_W'(PR_OPS - 1))
                    begin
                        state_reg <= ST_PR_WAIT;
                    end
                end
                ST_PR_WAIT:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    state_reg <= ST_MAG;
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath: z, c, magnitudes and the three accumulators
    always_ff @(posedge clk)
    begin
        if (prod_tag.valid)
        begin
            unique case (prod_tag.target)
                ACC_RE2: sq_re_reg <= sq_re_reg + addend;
                ACC_IM2: sq_im_reg <= sq_im_reg + addend;
                ACC_PRD: prd_reg   <= prd_reg + addend;
                default: ;
            endcase
        end
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            c_re_reg <= c_re_in;
            c_im_reg <= c_im_in;
            z_re_reg <= c_re_in;
            z_im_reg <= c_im_in;
        end
        if (state_reg == ST_MAG)
        begin
            mag_re_reg  <= mag_re_full[MAG_W-1:0];
            mag_im_reg  <= mag_im_full[MAG_W-1:0];
            neg_prd_reg <= z_re_reg[Z_W-1] ^ z_im_reg[Z_W-1];
            sq_re_reg   <= '0;
            sq_im_reg   <= '0;
        end
        if (state_reg == ST_TEST)
        begin
            prd_reg <= '0;
        end
        if (state_reg == ST_UPDATE)
        begin
            z_re_reg <= d_full[ACC_W-1:FRAC_W] + c_re_reg;
            z_im_reg <= p_full[ACC_W-2:FRAC_W-1] + c_im_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `MET_ASSERT_IMP(a_result_in_range, m_tvalid, (m_tdata == '0) || (m_tdata < lim_reg),
                    "escape step not below the iteration limit")
    `MET_ASSERT_IMP(a_square_operands_fit, state_reg == ST_SQ, !z_big,
                    "z squared while a component exceeds the magnitude width")
    `MET_ASSERT_IMP(a_step_below_limit, state_reg == ST_PR, step_reg < lim_reg,
                    "step counter ran past the iteration limit")
    `MET_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
                    "new item taken right after an accept")

endmodule
